>>> hw/rtl/msot_pkg.sv
// Package for the median slew offset tracker: sizes, payload types, register
// indexes, controller states and the control structs between the submodules.
// Depends on nothing; every other file of the block imports it.
package msot_pkg;

	localparam int MAX_WINDOW      = 32;
	localparam int TIME_BITS       = 48;
	localparam int OFFSET_BITS     = TIME_BITS + 1;
	localparam int WIN_BITS        = $clog2(MAX_WINDOW + 1);
	localparam int POS_BITS        = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_BITS        = $clog2(OFFSET_BITS);
	localparam int LIMIT_BITS      = 32;
	localparam int WINDOW_REG_BITS = 6;
	localparam int CFG_IDX_BITS    = 1;

	typedef logic        [TIME_BITS-1:0]    time_t;
	typedef logic signed [OFFSET_BITS-1:0]  offset_t;
	typedef logic signed [OFFSET_BITS:0]    diff_t;
	typedef logic        [WIN_BITS-1:0]     win_t;
	typedef logic        [POS_BITS-1:0]     pos_t;
	typedef logic        [CNT_BITS-1:0]     bit_cnt_t;
	typedef logic        [LIMIT_BITS-1:0]   limit_t;
	typedef logic        [MAX_WINDOW-1:0]   mask_t;
	typedef logic        [CFG_IDX_BITS-1:0] cfg_idx_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_WINDOW = 1'b0,
		REG_DRIFT  = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_SELECT,
		ST_SLEW,
		ST_LIMIT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic  start;
		win_t  rank;
		mask_t live;
	} sel_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} sel_stat_t;

	typedef struct packed {
		logic start;
		logic clear;
		logic first;
	} slew_req_t;

	typedef struct packed {
		logic done;
		logic snapped;
	} slew_stat_t;

endpackage

>>> hw/rtl/msot_if.sv
// Handshake channels of the offset tracker: the timestamp word in and the
// result word out, each with valid, ready and payload.
// Depends on msot_pkg.
interface msot_stamp_if;
	import msot_pkg::*;
	logic  valid;
	logic  ready;
	time_t server_time;
	time_t client_time;

	modport source (output valid, output server_time, output client_time, input ready);
	modport sink (input valid, input server_time, input client_time, output ready);
endinterface

interface msot_result_if;
	import msot_pkg::*;
	logic    valid;
	logic    ready;
	offset_t slewed_offset;
	offset_t window_median;
	logic    snapped;

	modport source (output valid, output slewed_offset, output window_median,
		output snapped, input ready);
	modport sink (input valid, input slewed_offset, input window_median,
		input snapped, output ready);
endinterface

>>> hw/rtl/msot_ring.sv
// Sample ring of the offset tracker: one circular shift register per entry,
// rotated one bit per cycle while rot_en is set, so each shows its top bit.
// Depends on msot_pkg.
module msot_ring (
	input  logic           clk,
	input  logic           wr_en,
	input  msot_pkg::pos_t wr_pos,
	input  msot_pkg::offset_t wr_data,
	input  logic           rot_en,
	output msot_pkg::mask_t top_bits
);
	import msot_pkg::*;

	offset_t entry_q [MAX_WINDOW];

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_WINDOW; i++) begin
			if (wr_en && wr_pos == POS_BITS'(i)) begin
				entry_q[i] <= wr_data;
			end else if (rot_en) begin
				entry_q[i] <= {entry_q[i][OFFSET_BITS-2:0], entry_q[i][OFFSET_BITS-1]};
			end
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_WINDOW; i++) begin
			top_bits[i] = entry_q[i][OFFSET_BITS-1];
		end
	end

endmodule

>>> hw/rtl/msot_select.sv
// Bit-serial rank selector: finds the entry of a given rank among the live
// ring entries, one result bit per cycle from the sign bit down.
// Depends on msot_pkg.
module msot_select (
	input  logic                clk,
	input  logic                arst_n,
	input  msot_pkg::sel_req_t  req,
	input  msot_pkg::mask_t     top_bits,
	output msot_pkg::sel_stat_t stat,
	output msot_pkg::offset_t   median
);
	import msot_pkg::*;

	logic     busy_q;
	bit_cnt_t cnt_q;
	win_t     rank_q;
	mask_t    live_q;
	offset_t  med_q;

	logic  first_bit;
	logic  last_bit;
	mask_t cand;
	mask_t low_mask;
	win_t  low_cnt;
	logic  go_low;

	always_comb begin
		first_bit = (cnt_q == '0);
		last_bit  = (cnt_q == CNT_BITS'(OFFSET_BITS - 1));
		// The sign bit orders the other way round, so it is inverted.
		cand      = top_bits ^ {MAX_WINDOW{first_bit}};
		low_mask  = live_q & ~cand;
		low_cnt   = '0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			low_cnt = low_cnt + WIN_BITS'(low_mask[i]);
		end
		go_low = (rank_q < low_cnt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last_bit) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rank_q <= req.rank;
			live_q <= req.live;
		end else if (busy_q) begin
			if (go_low) begin
				live_q <= low_mask;
			end else begin
				live_q <= live_q & cand;
				rank_q <= rank_q - low_cnt;
			end
			med_q <= {med_q[OFFSET_BITS-2:0], (~go_low) ^ first_bit};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = busy_q && last_bit;
	assign median    = med_q;

	a_rank_in_live: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (32'(rank_q) < $countones(live_q)))
		else $error("selector rank lies outside the live entries");

	a_busy_run: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !last_bit && !req.start) |=> (busy_q && cnt_q == $past(cnt_q) + 1'b1))
		else $error("selector pass stopped early");

endmodule

>>> hw/rtl/msot_slew.sv
// Slew limiter: keeps the applied offset and moves it toward the median by
// at most the drift limit, or snaps it on the first sample.
// Depends on msot_pkg.
module msot_slew (
	input  logic                 clk,
	input  logic                 arst_n,
	input  msot_pkg::slew_req_t  req,
	input  msot_pkg::offset_t    median,
	input  msot_pkg::limit_t     limit,
	output msot_pkg::slew_stat_t stat,
	output msot_pkg::offset_t    applied
);
	import msot_pkg::*;

	offset_t cur_q;
	logic    run_s1;
	logic    first_s1;
	diff_t   diff_s1;

	offset_t lim_off;
	diff_t   lim_ext;
	logic    above;
	logic    below;
	offset_t cur_next;

	always_comb begin
		lim_off = {{(OFFSET_BITS - LIMIT_BITS){1'b0}}, limit};
		lim_ext = {{(OFFSET_BITS + 1 - LIMIT_BITS){1'b0}}, limit};
		above   = (diff_s1 > lim_ext);
		below   = (diff_s1 < -lim_ext);
		if (first_s1) begin
			cur_next = median;
		end else if (above) begin
			cur_next = cur_q + lim_off;
		end else if (below) begin
			cur_next = cur_q - lim_off;
		end else begin
			cur_next = median;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q    <= '0;
			run_s1   <= 1'b0;
			first_s1 <= 1'b0;
		end else begin
			run_s1 <= req.start;
			if (req.start) begin
				first_s1 <= req.first;
			end
			if (req.clear) begin
				cur_q <= '0;
			end else if (run_s1) begin
				cur_q <= cur_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			diff_s1 <= diff_t'(median) - diff_t'(cur_q);
		end
	end

	assign stat.done    = run_s1;
	assign stat.snapped = first_s1;
	assign applied      = cur_q;

endmodule

>>> hw/rtl/median_slew_offset_tracker_core.sv
// Median slew offset tracker, top level: controller, configuration and result register.
// Each accepted timestamp word is written to the ring, passes the bit-serial median
// pass and the slew limiter and loads its result word before a new word is accepted.
// A waiting result does not stop the next timestamp word from being accepted.
// Reset clears the sample state and sets window 1, drift limit 0; no clearing pass.
// Depends on msot_pkg, msot_if, msot_ring, msot_select and msot_slew.
module median_slew_offset_tracker_core (
	input  logic               clk,
	input  logic               arst_n,
	msot_stamp_if.sink         stamp,
	msot_result_if.source      result,
	input  logic               wr_en,
	input  msot_pkg::cfg_idx_t wr_index,
	input  msot_pkg::limit_t   wr_data
);
	import msot_pkg::*;

	state_t  state_q;
	state_t  state_next;
	win_t    win_q;
	limit_t  lim_q;
	pos_t    pos_q;
	win_t    fill_q;
	logic    has_first_q;
	time_t   srv_q;
	time_t   cli_q;
	logic    out_valid_q;
	offset_t out_app_q;
	offset_t out_med_q;
	logic    out_snap_q;

	logic                  win_wr;
	logic [WINDOW_REG_BITS-1:0] win_raw;
	win_t                  win_new;
	win_t                  fill_next;
	pos_t                  pos_next;
	offset_t               raw_diff;
	logic                  ring_wr;
	mask_t                 top_bits;
	sel_req_t              sel_req;
	sel_stat_t             sel_stat;
	offset_t               median;
	slew_req_t             slew_req;
	slew_stat_t            slew_stat;
	offset_t               applied;
	logic                  out_load;
	logic                  take;

	always_comb begin
		win_wr  = wr_en && (wr_index == REG_WINDOW);
		win_raw = wr_data[WINDOW_REG_BITS-1:0];
		if (win_raw == '0) begin
			win_new = WIN_BITS'(1);
		end else if (32'(win_raw) > MAX_WINDOW) begin
			win_new = WIN_BITS'(MAX_WINDOW);
		end else begin
			win_new = WIN_BITS'(win_raw);
		end
		fill_next = (fill_q < win_q) ? fill_q + 1'b1 : fill_q;
		if (WIN_BITS'(pos_q) + 1'b1 >= win_q) begin
			pos_next = '0;
		end else begin
			pos_next = pos_q + 1'b1;
		end
		raw_diff = offset_t'({1'b0, srv_q}) - offset_t'({1'b0, cli_q});
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (stamp.valid) begin
					state_next = ST_WRITE;
				end
			end
			ST_WRITE: state_next = ST_SELECT;
			ST_SELECT: begin
				if (sel_stat.done) begin
					state_next = ST_SLEW;
				end
			end
			ST_SLEW: state_next = ST_LIMIT;
			ST_LIMIT: begin
				if (slew_stat.done) begin
					state_next = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || result.ready) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		stamp.ready    = 1'b0;
		ring_wr        = 1'b0;
		sel_req.start  = 1'b0;
		sel_req.rank   = fill_next >> 1;
		slew_req.start = 1'b0;
		slew_req.clear = win_wr;
		slew_req.first = !has_first_q;
		out_load       = 1'b0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			sel_req.live[i] = (32'(i) < 32'(fill_next));
		end
		unique case (state_q)
			ST_IDLE: stamp.ready = 1'b1;
			ST_WRITE: begin
				ring_wr       = 1'b1;
				sel_req.start = 1'b1;
			end
			ST_SELECT: ;
			ST_SLEW: slew_req.start = 1'b1;
			ST_LIMIT: ;
			ST_OUT: out_load = !out_valid_q || result.ready;
			default: ;
		endcase
	end

	assign take = stamp.valid && stamp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			win_q       <= WIN_BITS'(1);
			lim_q       <= '0;
			pos_q       <= '0;
			fill_q      <= '0;
			has_first_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (win_wr) begin
				win_q       <= win_new;
				pos_q       <= '0;
				fill_q      <= '0;
				has_first_q <= 1'b0;
			end else begin
				if (ring_wr) begin
					pos_q  <= pos_next;
					fill_q <= fill_next;
				end
				if (out_load) begin
					has_first_q <= 1'b1;
				end
			end
			if (wr_en && wr_index == REG_DRIFT) begin
				lim_q <= wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			srv_q <= stamp.server_time;
			cli_q <= stamp.client_time;
		end
		if (out_load) begin
			out_app_q  <= applied;
			out_med_q  <= median;
			out_snap_q <= slew_stat.snapped;
		end
	end

	msot_ring u_ring (
		.clk      (clk),
		.wr_en    (ring_wr),
		.wr_pos   (pos_q),
		.wr_data  (raw_diff),
		.rot_en   (sel_stat.busy),
		.top_bits (top_bits)
	);

	msot_select u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (sel_req),
		.top_bits (top_bits),
		.stat     (sel_stat),
		.median   (median)
	);

	msot_slew u_slew (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (slew_req),
		.median  (median),
		.limit   (lim_q),
		.stat    (slew_stat),
		.applied (applied)
	);

	assign result.valid          = out_valid_q;
	assign result.slewed_offset  = out_app_q;
	assign result.window_median  = out_med_q;
	assign result.snapped        = out_snap_q;

	a_fill_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= win_q)
		else $error("sample count exceeds the window");

	a_pos_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		WIN_BITS'(pos_q) < win_q)
		else $error("ring position outside the window");

	a_first_has_sample: assert property (@(posedge clk) disable iff (!arst_n)
		has_first_q |-> (fill_q != '0))
		else $error("offset tracking started without a sample");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_OUT))
		else $error("result word raised outside the output step");

endmodule

>>> tb/median_slew_offset_tracker_core_test.sv
// Self-checking bench for the median slew offset tracker core: it drives timestamp words
// with bursty gaps, stalls the result side and predicts each result word in a scoreboard.
// Depends on msot_pkg, msot_if and the median_slew_offset_tracker_core RTL.
`timescale 1ns / 100ps

class offset_scoreboard;
	typedef struct {
		msot_pkg::offset_t applied;
		msot_pkg::offset_t median;
		logic              snapped;
	} tracked_t;

	longint      ring[msot_pkg::MAX_WINDOW];
	int unsigned head;
	int unsigned filled;
	int unsigned span;
	bit          seeded;
	longint      offset_now;
	longint      slew_cap;
	tracked_t    due[$];
	int unsigned errors;

	function new();
		span = 1;
		slew_cap = 0;
		errors = 0;
		clear_samples();
	endfunction

	function void clear_samples();
		head = 0;
		filled = 0;
		seeded = 0;
		offset_now = 0;
	endfunction

	function void set_window(logic [31:0] data);
		int unsigned w;
		w = data[5:0];
		if (w > msot_pkg::MAX_WINDOW) w = msot_pkg::MAX_WINDOW;
		if (w == 0) w = 1;
		span = w;
		clear_samples();
	endfunction

	function void set_drift(logic [31:0] data);
		slew_cap = longint'({32'd0, data});
	endfunction

	function void note_stamp(msot_pkg::time_t server, msot_pkg::time_t client);
		longint      sorted[msot_pkg::MAX_WINDOW];
		longint      pick;
		longint      v;
		longint      gap;
		int unsigned i;
		int unsigned j;
		tracked_t    t;
		ring[head] = $signed({16'd0, server}) - $signed({16'd0, client});
		head = (head + 1) % span;
		if (filled < span) filled++;
		for (i = 0; i < filled; i++) begin
			v = ring[i];
			j = i;
			while (j > 0 && sorted[j-1] > v) begin
				sorted[j] = sorted[j-1];
				j--;
			end
			sorted[j] = v;
		end
		pick = sorted[filled/2];
		t.snapped = !seeded;
		if (!seeded) begin
			offset_now = pick;
			seeded = 1;
		end else begin
			gap = pick - offset_now;
			if (gap > slew_cap) offset_now += slew_cap;
			else if (gap < -slew_cap) offset_now -= slew_cap;
			else offset_now = pick;
		end
		t.applied = offset_now[48:0];
		t.median = pick[48:0];
		due.push_back(t);
	endfunction

	task report(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	task check_result(msot_pkg::offset_t applied, msot_pkg::offset_t median,
		logic snapped);
		tracked_t t;
		if (due.size() == 0) begin
			report($sformatf("result word with none outstanding, offset %0d", applied));
			return;
		end
		t = due.pop_front();
		if (applied !== t.applied)
			report($sformatf("slewed_offset %0d, predicted %0d", applied, t.applied));
		if (median !== t.median)
			report($sformatf("window_median %0d, predicted %0d", median, t.median));
		if (snapped !== t.snapped)
			report($sformatf("snapped %b, predicted %b", snapped, t.snapped));
	endtask

	function int unsigned pending();
		return due.size();
	endfunction
endclass

module median_slew_offset_tracker_core_test;
	import msot_pkg::*;

	localparam time_t TIME_MAX = '1;

	logic             clk;
	logic             arst_n;
	logic             wr_en;
	cfg_idx_t         wr_index;
	limit_t           wr_data;
	bit               hold_request;
	longint           centre;
	int unsigned      burst_left;
	offset_scoreboard tracker;

	msot_stamp_if  stamp();
	msot_result_if result();

	median_slew_offset_tracker_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.stamp    (stamp),
		.result   (result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic write_reg(cfg_reg_t idx, limit_t data);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_WINDOW) tracker.set_window(data);
		else tracker.set_drift(data);
	endtask

	task automatic send_word(time_t server, time_t client);
		stamp.valid <= 1'b1;
		stamp.server_time <= server;
		stamp.client_time <= client;
		do @(posedge clk); while (!stamp.ready);
		tracker.note_stamp(server, client);
	endtask

	task automatic pause_sender();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			if ($urandom_range(0, 3) != 0) begin
				stamp.valid <= 1'b0;
				repeat ($urandom_range(1, 120)) @(posedge clk);
			end
			burst_left = $urandom_range(0, 15);
		end
	endtask

	task automatic drain();
		stamp.valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic time_t rnd_time();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[47:0];
	endfunction

	function automatic time_t edge_time();
		case ($urandom_range(0, 2))
			0: return '0;
			1: return TIME_MAX;
			default: return rnd_time();
		endcase
	endfunction

	// Nearly half the words sit near a common offset so that the median and the slew limit interact.
	task automatic make_pair(output time_t server, output time_t client);
		int unsigned pick;
		time_t       c;
		longint      jitter;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			server = rnd_time();
			client = rnd_time();
		end else if (pick < 85) begin
			if ($urandom_range(0, 19) == 0)
				centre = longint'($urandom_range(0, 32'd4194304)) - 64'sd2097152;
			c = rnd_time();
			c[47:46] = 2'b01;
			jitter = longint'($urandom_range(0, 4000)) - 64'sd2000;
			client = c;
			server = time_t'(longint'({16'd0, c}) + centre + jitter);
		end else begin
			server = edge_time();
			client = edge_time();
		end
	endtask

	initial begin
		int unsigned fill;
		fill = 0;
		result.ready <= 1'b0;
		forever begin
			int unsigned mode;
			int unsigned mode_left;
			@(posedge clk);
			if (result.valid && result.ready)
				tracker.check_result(result.slewed_offset, result.window_median,
					result.snapped);
			if (hold_request) begin
				hold_request = 0;
				fill = 600;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 300);
			end else begin
				mode_left--;
			end
			if (fill > 0) begin
				fill--;
				result.ready <= 1'b0;
			end else begin
				case (mode)
					0: result.ready <= 1'b1;
					1: result.ready <= $urandom_range(0, 1);
					2: result.ready <= ($urandom_range(0, 7) == 0);
					default: result.ready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	initial begin
		#(20_000_000);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		time_t       s;
		time_t       c;
		int unsigned sent;
		int unsigned n;
		int unsigned i;
		int unsigned k;
		int unsigned w;
		limit_t      data;
		tracker = new();
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= REG_WINDOW;
		wr_data <= '0;
		stamp.valid <= 1'b0;
		stamp.server_time <= '0;
		stamp.client_time <= '0;
		hold_request = 0;
		centre = 0;
		burst_left = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// After reset the window is one sample and the offset cannot move after the snap.
		send_word(TIME_MAX, '0);
		send_word('0, TIME_MAX);
		send_word(48'd5, 48'd5);
		drain();
		// A new drift limit keeps the sample state, so the next word does not snap.
		write_reg(REG_DRIFT, 32'hFFFF_FFFF);
		send_word(48'd7, 48'd3);
		drain();
		write_reg(REG_WINDOW, 32'd4);
		send_word(48'd100, 48'd0);
		send_word(48'd0, 48'd50);
		send_word(48'd300, 48'd0);
		send_word(48'd10, 48'd20);
		send_word(TIME_MAX, TIME_MAX);
		send_word('0, '0);
		drain();
		write_reg(REG_DRIFT, 32'd0);
		write_reg(REG_WINDOW, 32'hFFFF_FFC0);
		send_word(48'd1, 48'd2);
		send_word(48'd2, 48'd1);
		drain();
		write_reg(REG_WINDOW, 32'h0000_003F);
		write_reg(REG_DRIFT, 32'd1000);
		send_word(48'd5000, 48'd0);
		send_word(48'd0, 48'd5000);
		send_word(48'd2000, 48'd1999);
		send_word(48'd1, 48'd0);
		send_word(TIME_MAX, TIME_MAX - 48'd3000);
		send_word(48'd9000, 48'd1);
		drain();

		// The result side holds off while words keep coming, so the input backs up.
		hold_request = 1;
		for (i = 0; i < 10; i++) begin
			make_pair(s, c);
			send_word(s, c);
		end
		drain();

		sent = 0;
		while (sent < 1000) begin
			k = $urandom_range(0, 9);
			if (k != 9) begin
				if (k < 6) w = $urandom_range(1, 32);
				else if (k == 6) w = 32;
				else if (k == 7) w = 1;
				else if ($urandom_range(0, 1) == 0) w = 0;
				else w = $urandom_range(33, 63);
				data = ($urandom & ~32'h3F) | w;
				write_reg(REG_WINDOW, data);
			end
			if (k == 9 || $urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 5))
					0: data = '0;
					1: data = '1;
					2: data = $urandom;
					default: data = $urandom_range(0, 3000);
				endcase
				write_reg(REG_DRIFT, data);
			end
			n = $urandom_range(5, 80);
			for (i = 0; i < n; i++) begin
				make_pair(s, c);
				send_word(s, c);
				if (i != n - 1) pause_sender();
			end
			sent += n;
			drain();
		end

		repeat (60) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule

>>> filelist.f
hw/rtl/msot_pkg.sv
hw/rtl/msot_if.sv
hw/rtl/msot_ring.sv
hw/rtl/msot_select.sv
hw/rtl/msot_slew.sv
hw/rtl/median_slew_offset_tracker_core.sv
tb/median_slew_offset_tracker_core_test.sv
